FILE: rtl/dkf_pkg.sv
// Package for the DES key fan-fold block: widths, weak-key table and
// the bit permutation / parity helpers shared by the front and back ends.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dkf_pkg;

    localparam int KEY_W       = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_WEAK    = 16;

    localparam logic [KEY_W-1:0] LOW7_MASK = 64'h7F7F_7F7F_7F7F_7F7F;
    localparam logic [7:0]       WEAK_FIX  = 8'hF0;

    localparam logic [KEY_W-1:0] WEAK_KEYS [NUM_WEAK] = '{
        64'h0101010101010101, 64'h1F1F1F1F0E0E0E0E,
        64'hE0E0E0E0F1F1F1F1, 64'hFEFEFEFEFEFEFEFE,
        64'h01FE01FE01FE01FE, 64'h1FE01FE00EF10EF1,
        64'h01E001E001F101F1, 64'h1FFE1FFE0EFE0EFE,
        64'h011F011F010E010E, 64'hE0FEE0FEF1FEF1FE,
        64'hFE01FE01FE01FE01, 64'hE01FE01FF10EF10E,
        64'hE001E001F101F101, 64'hFE1FFE1FFE0EFE0E,
        64'h1F011F010E010E01, 64'hFEE0FEE0FEF1FEF1
    };

    // Reverse the 56 data bits: mirror the bytes and flip the 7 bits inside each.
    function automatic logic [KEY_W-1:0] reverse56(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 7; i++) begin
                r[8*k + 6 - i] = v[8*(7-k) + i];
            end
        end
        return r;
    endfunction

    // Shift each byte left by one and set odd parity in bit 0.
    function automatic logic [KEY_W-1:0] shift_parity(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = {v[8*k +: 7], ~(^v[8*k +: 7])};
        end
        return r;
    endfunction

    function automatic logic is_weak(input logic [KEY_W-1:0] key);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_WEAK; i++) begin
            if (key == WEAK_KEYS[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dkf_ifs.sv
// Stream interfaces for the fan-fold block: the block input channel and
// the key result channel. Depends on dkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dkf_in_if;
    import dkf_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] block;
    logic             last_block;

    modport source (output valid, output block, output last_block, input ready);
    modport sink   (input valid, input block, input last_block, output ready);
endinterface

interface dkf_out_if;
    import dkf_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] temp_key;
    logic             weak_fixed;

    modport source (output valid, output temp_key, output weak_fixed, input ready);
    modport sink   (input valid, input temp_key, input weak_fixed, output ready);
endinterface

`default_nettype wire

FILE: rtl/dkf_front.sv
// Front end: accepts blocks, strips top bits, reverses every second block
// and folds it into the accumulator; pushes the fold on the last block.
// Depends on dkf_pkg and dkf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dkf_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    dkf_in_if.sink                        din,
    input  wire logic                     q_full,
    output logic                          push,
    output logic [dkf_pkg::KEY_W-1:0]     push_data
);
    import dkf_pkg::*;

    logic [KEY_W-1:0] acc_reg, acc_next;
    logic             rev_reg, rev_next;
    logic [KEY_W-1:0] masked;
    logic [KEY_W-1:0] folded;
    logic             accept;

    assign din.ready = ~q_full;
    assign accept    = din.valid & din.ready;
    assign masked    = din.block & LOW7_MASK;
    assign folded    = acc_reg ^ (rev_reg ? reverse56(masked) : masked);
    assign push      = accept & din.last_block;
    assign push_data = folded;

    always_comb
    begin
        acc_next = acc_reg;
        rev_next = rev_reg;
        if (accept)
        begin
            if (din.last_block)
            begin
                acc_next = '0;
                rev_next = 1'b0;
            end
            else
            begin
                acc_next = folded;
                rev_next = ~rev_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rev_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            rev_reg <= rev_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dkf_queue.sv
// Short FIFO between front and back end holding finished folds.
// Depends on dkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dkf_queue #(
    parameter int DEPTH = dkf_pkg::QUEUE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic [dkf_pkg::KEY_W-1:0] push_data,
    input  wire logic                     pop,
    output logic                          q_valid,
    output logic                          q_full,
    output logic [dkf_pkg::KEY_W-1:0]     q_data
);
    import dkf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [KEY_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_valid = (cnt_reg != '0);
    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dkf_back.sv
// Back end: takes a fold from the queue, applies shift and odd parity,
// fixes weak keys and holds the result in the output register.
// Depends on dkf_pkg and dkf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dkf_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire logic [dkf_pkg::KEY_W-1:0] q_data,
    output logic                           pop,
    dkf_out_if.source                      dout
);
    import dkf_pkg::*;

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             weak_reg, weak_next;
    logic [KEY_W-1:0] par_key;
    logic             hit;

    assign par_key = shift_parity(q_data);
    assign hit     = is_weak(par_key);
    assign pop     = q_valid & (~valid_reg | dout.ready);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        weak_next  = weak_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            key_next   = par_key ^ {{(KEY_W-8){1'b0}}, (hit ? WEAK_FIX : 8'h00)};
            weak_next  = hit;
        end
        else if (dout.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        weak_reg <= weak_next;
    end

    assign dout.valid      = valid_reg;
    assign dout.temp_key   = key_reg;
    assign dout.weak_fixed = weak_reg;

endmodule

`default_nettype wire

FILE: rtl/des_key_fanfold.sv
// Fan-fold stage of DES string-to-key: one 8-byte block per cycle while the fold queue has room.
// The key for a last block passes through the fold queue, then the output register, to dout.
// din accepts one beat per cycle while the fold queue is not full.
// din.ready drops only while the fold queue is full (dout stalled for several keys).
// Reset (rst_n low, asynchronous): accumulator, reversal flag, queue and output valid clear.
`timescale 1ns / 1ps
`default_nettype none

module des_key_fanfold #(
    parameter int QUEUE_DEPTH = dkf_pkg::QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dkf_in_if.sink    din,
    dkf_out_if.source dout
);
    import dkf_pkg::*;

    // Fold path between front end and queue
    logic             push;
    logic [KEY_W-1:0] push_data;

    // Queue head toward the back end
    logic             q_valid;
    logic             q_full;
    logic [KEY_W-1:0] q_data;
    logic             pop;

    // Front: mask, conditionally reverse, fold; push the finished fold on the last beat
    dkf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple: hold finished folds while the result side stalls
    dkf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_data    (q_data)
    );

    // Back: parity, weak-key fix, output register
    dkf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .dout    (dout)
    );

endmodule

`default_nettype wire

FILE: rtl/dkf_checker.sv
// Port-level checks on the key output of the fan-fold block, and the bind
// that attaches them to des_key_fanfold. Depends on dkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dkf_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [dkf_pkg::KEY_W-1:0] temp_key,
    input wire logic                      weak_fixed
);
    import dkf_pkg::*;

    // Every key byte carries odd parity.
    a_odd_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (^temp_key[63:56]) && (^temp_key[55:48]) && (^temp_key[47:40])
            && (^temp_key[39:32]) && (^temp_key[31:24]) && (^temp_key[23:16])
            && (^temp_key[15:8]) && (^temp_key[7:0]))
        else $error("temp_key byte with even parity");

    // A fixed key ends in a byte derived from a weak-key byte.
    a_fix_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && weak_fixed |-> temp_key[7:0] == 8'hF1 || temp_key[7:0] == 8'hFE
            || temp_key[7:0] == 8'h01 || temp_key[7:0] == 8'h0E)
        else $error("weak_fixed with unexpected last byte");

    // An unfixed key never equals a weak key.
    a_no_weak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !weak_fixed |-> !is_weak(temp_key))
        else $error("weak key delivered without fix");

    // Stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temp_key) && $stable(weak_fixed))
        else $error("result changed under stall");

endmodule

bind des_key_fanfold dkf_checker u_dkf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .temp_key   (dout.temp_key),
    .weak_fixed (dout.weak_fixed)
);

`default_nettype wire

FILE: bench/des_key_fanfold_tb.sv
// Self-checking bench for des_key_fanfold: directed string table, then random strings,
// each key beat checked against a hand-typed key or an in-bench fan-fold predictor.
// Depends on dkf_pkg, dkf_in_if / dkf_out_if and the des_key_fanfold RTL.
`timescale 1ns / 1ps

module des_key_fanfold_tb;
    import dkf_pkg::*;

    typedef bit bool_t;

    // One key beat: what the result channel carries.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             was_weak;
    } key_beat_t;

    // One row of the directed table. Where typed is set, the key and weak
    // flag are written out by hand; every other row goes through the predictor.
    typedef struct packed {
        logic [KEY_W-1:0] blk;
        logic             last;
        logic             typed;
        logic [KEY_W-1:0] key;
        logic             was_weak;
    } string_row_t;

    localparam int               N_ROWS       = 18;
    localparam int               N_RANDOM     = 850;
    localparam logic [KEY_W-1:0] DATA_BITS    = 64'h7F7F_7F7F_7F7F_7F7F;
    localparam logic [7:0]       WEAK_TOGGLE  = 8'hF0;
    localparam int               N_WEAK       = 16;

    // Weak and semiweak DES keys, with odd parity already applied.
    localparam logic [KEY_W-1:0] WEAK_LIST [N_WEAK] = '{
        64'h0101010101010101, 64'h1F1F1F1F0E0E0E0E,
        64'hE0E0E0E0F1F1F1F1, 64'hFEFEFEFEFEFEFEFE,
        64'h01FE01FE01FE01FE, 64'h1FE01FE00EF10EF1,
        64'h01E001E001F101F1, 64'h1FFE1FFE0EFE0EFE,
        64'h011F011F010E010E, 64'hE0FEE0FEF1FEF1FE,
        64'hFE01FE01FE01FE01, 64'hE01FE01FF10EF10E,
        64'hE001E001F101F101, 64'hFE1FFE1FFE0EFE0E,
        64'h1F011F010E010E01, 64'hFEE0FEE0FEF1FEF1
    };

    // Directed strings. Typed keys are read straight off the scheme:
    // a zero accumulator spreads to 01 bytes, all-ones data to FE bytes,
    // and both are weak, so byte 7 gets F0 flipped in.
    string_row_t dir_rows [N_ROWS] = '{
        // single zero block right after reset: weak key, byte 7 flipped
        '{64'h0000000000000000, 1'b1, 1'b1, 64'h01010101010101F1, 1'b1},
        // all ones: top bits dropped, FE key is weak
        '{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1, 64'hFEFEFEFEFEFEFE0E, 1'b1},
        // only top bits set: they vanish, same key as the zero block
        '{64'h8080808080808080, 1'b1, 1'b1, 64'h01010101010101F1, 1'b1},
        // folds to 1F1F1F1F0E0E0E0E
        '{64'h0F0F0F0F07070707, 1'b1, 1'b1, 64'h1F1F1F1F0E0E0EFE, 1'b1},
        // folds to the semiweak key E01FE01FF10EF10E
        '{64'h700F700F78077807, 1'b1, 1'b1, 64'hE01FE01FF10EF1FE, 1'b1},
        // plain key with mixed parity per byte, not weak
        '{64'h0001020304050607, 1'b1, 1'b1, 64'h01020407080B0D0E, 1'b0},
        // two blocks: second one gets mirrored
        '{64'h0102030405060708, 1'b0, 1'b0, '0, 1'b0},
        '{64'h1122334455667788, 1'b1, 1'b0, '0, 1'b0},
        // three blocks with top bits scattered about
        '{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, '0, 1'b0},
        '{64'h8000000000000001, 1'b0, 1'b0, '0, 1'b0},
        '{64'h7F00000000000000, 1'b1, 1'b0, '0, 1'b0},
        // four blocks: second and fourth get mirrored
        '{64'h4000000000000000, 1'b0, 1'b0, '0, 1'b0},
        '{64'h0000000000000001, 1'b0, 1'b0, '0, 1'b0},
        '{64'hAAAAAAAAAAAAAAAA, 1'b0, 1'b0, '0, 1'b0},
        '{64'h5555555555555555, 1'b1, 1'b0, '0, 1'b0},
        // a mirrored all-ones block cancels the first one: zero key again
        '{64'h7F7F7F7F7F7F7F7F, 1'b0, 1'b0, '0, 1'b0},
        '{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0, '0, 1'b0},
        '{64'h0123456789ABCDEF, 1'b1, 1'b0, '0, 1'b0}
    };

    logic clk;
    logic rst_n;

    dkf_in_if  din_if ();
    dkf_out_if dout_if ();

    des_key_fanfold u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // Predictor state: running XOR of folded blocks and the mirror toggle.
    logic [KEY_W-1:0] fold_acc;
    logic             mirror_pending;

    key_beat_t pending_keys [$];
    int        error_count;

    // Calm flags: while set, that side never idles.
    bit calm_src;
    bit calm_snk;

    always #1 clk = ~clk;

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Reverse the 56 data bits as one string: gather the 7-bit groups,
    // flip the whole run end to end, then scatter them back.
    function automatic logic [KEY_W-1:0] mirror56(input logic [KEY_W-1:0] v);
        logic [55:0]      packed_in;
        logic [55:0]      packed_out;
        logic [KEY_W-1:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            packed_in[7*k +: 7] = v[8*k +: 7];
        end
        for (int j = 0; j < 56; j++)
        begin
            packed_out[j] = packed_in[55-j];
        end
        for (int k = 0; k < 8; k++)
        begin
            r[8*k +: 7] = packed_out[7*k +: 7];
        end
        return r;
    endfunction

    // Move each 7-bit group up one place; bit 0 makes the byte's ones count odd.
    function automatic logic [KEY_W-1:0] spread_parity(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        logic [6:0]       grp;
        for (int k = 0; k < 8; k++)
        begin
            grp          = v[8*k +: 7];
            r[8*k +: 8]  = {grp, ($countones(grp) % 2) == 0};
        end
        return r;
    endfunction

    // Fold one accepted block; return 1 and the key beat when it closes a string.
    function automatic bit fold_block(input logic [KEY_W-1:0] blk, input logic last,
                                      output key_beat_t beat);
        logic [KEY_W-1:0] data;
        logic [KEY_W-1:0] key;
        data = blk & DATA_BITS;
        if (mirror_pending)
        begin
            data = mirror56(data);
        end
        mirror_pending = ~mirror_pending;
        fold_acc       = fold_acc ^ data;
        beat           = '0;
        if (!last)
        begin
            return 1'b0;
        end
        key = spread_parity(fold_acc);
        for (int i = 0; i < N_WEAK; i++)
        begin
            if (key == WEAK_LIST[i])
            begin
                beat.was_weak = 1'b1;
            end
        end
        if (beat.was_weak)
        begin
            key[7:0] = key[7:0] ^ WEAK_TOGGLE;
        end
        beat.key       = key;
        fold_acc       = '0;
        mirror_pending = 1'b0;
        return 1'b1;
    endfunction

    // Drive one block: idle for a random gap, hold valid until ready, then
    // fold it into the predictor. With no gap, valid stays high into the next beat.
    task automatic send_block(input logic [KEY_W-1:0] blk, input logic last,
                              input logic typed, input logic [KEY_W-1:0] typed_key,
                              input logic typed_weak);
        int        gap;
        key_beat_t beat;
        gap = calm_src ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid      <= 1'b1;
        din_if.block      <= blk;
        din_if.last_block <= last;
        do @(posedge clk); while (!din_if.ready);
        if (fold_block(blk, last, beat))
        begin
            if (typed)
            begin
                beat.key      = typed_key;
                beat.was_weak = typed_weak;
            end
            pending_keys.push_back(beat);
        end
    endtask

    // Result side: stall a random count per beat, sometimes not at all for a stretch.
    initial
    begin
        int stall;
        forever
        begin
            stall = calm_snk ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            do @(posedge clk); while (!(dout_if.valid && rst_n));
            if ($urandom_range(0, 15) == 0)
            begin
                calm_snk = ~calm_snk;
            end
        end
    end

    // Check every key beat against the oldest predicted key.
    always @(posedge clk)
    begin
        key_beat_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (pending_keys.size() == 0)
            begin
                flag_error($sformatf("unexpected key beat %h weak=%b",
                                     dout_if.temp_key, dout_if.weak_fixed));
            end
            else
            begin
                want = pending_keys.pop_front();
                if (dout_if.temp_key !== want.key)
                begin
                    flag_error($sformatf("temp_key %h, want %h",
                                         dout_if.temp_key, want.key));
                end
                if (dout_if.weak_fixed !== want.was_weak)
                begin
                    flag_error($sformatf("weak_fixed %b, want %b (key %h)",
                                         dout_if.weak_fixed, want.was_weak, want.key));
                end
            end
        end
    end

    initial
    begin
        int               sent;
        int               str_len;
        int               waited;
        bool_t            aim_weak;
        logic [KEY_W-1:0] blk;
        logic [KEY_W-1:0] aim_data;

        // Hold every input at a known value from time zero.
        clk               = 1'b0;
        rst_n             <= 1'b0;
        din_if.valid      <= 1'b0;
        din_if.block      <= '0;
        din_if.last_block <= 1'b0;
        fold_acc          = '0;
        mirror_pending    = 1'b0;
        error_count       = 0;
        calm_src          = 1'b0;
        calm_snk          = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        for (int r = 0; r < N_ROWS; r++)
        begin
            send_block(dir_rows[r].blk, dir_rows[r].last, dir_rows[r].typed,
                       dir_rows[r].key, dir_rows[r].was_weak);
        end

        // Random strings: mostly short, a few long. About a quarter aim the
        // final block so that the fold lands on a weak or semiweak key.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            calm_src = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 19))
                0:       str_len = $urandom_range(11, 24);
                1, 2, 3,
                4, 5:    str_len = $urandom_range(5, 10);
                default: str_len = $urandom_range(1, 4);
            endcase
            aim_weak = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < str_len; b++)
            begin
                blk = {$urandom, $urandom};
                if (aim_weak && b == str_len - 1)
                begin
                    // Pick the data that folds the accumulator onto the target.
                    aim_data = ((WEAK_LIST[$urandom_range(0, N_WEAK-1)] >> 1) & DATA_BITS)
                               ^ fold_acc;
                    if (mirror_pending)
                    begin
                        aim_data = mirror56(aim_data);
                    end
                    blk = aim_data | (blk & ~DATA_BITS);
                end
                send_block(blk, b == str_len - 1, 1'b0, '0, 1'b0);
                sent++;
            end
        end
        din_if.valid <= 1'b0;

        // Drain: let outstanding keys arrive, then watch a little longer for strays.
        waited = 0;
        while (pending_keys.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_keys.size() != 0)
        begin
            flag_error($sformatf("%0d key(s) never arrived", pending_keys.size()));
        end
        repeat (8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
